FILE: design/acmac_pkg.sv
package acmac_pkg;

  localparam int unsigned BlockW   = 128;
  localparam int unsigned HalfW    = 64;
  localparam int unsigned CntW     = 5;
  localparam int unsigned NumRk    = 11;
  localparam int unsigned RoundW   = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam logic [7:0]  RbConst  = 8'h87;
  localparam logic [7:0]  PadMark  = 8'h80;
  localparam logic [CntW-1:0] BlockBytes = 5'd16;

  localparam logic [CfgIdxW-1:0] RegKeyUpper = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLower = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  typedef struct packed {
    logic [HalfW-1:0]  data_upper;
    logic [HalfW-1:0]  data_lower;
    logic [CntW-1:0]   valid_bytes;
    logic              last_block;
  } in_item_t;

  typedef struct packed {
    logic [HalfW-1:0] tag_upper;
    logic [HalfW-1:0] tag_lower;
  } out_item_t;

  // control between sequencer and round unit
  typedef struct packed {
    logic        load;      // load state = data ^ rk0
    logic        step;      // run one round with rk
    logic        last;      // final round (no MixColumns)
  } rnd_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block, byte 0 most significant
  function automatic logic [7:0] byte_of(input block_t b, input int unsigned i);
    return b[BlockW-1-8*i -: 8];
  endfunction

  function automatic block_t gf_double(input block_t x);
    return {x[BlockW-2:0], 1'b0} ^ {{(BlockW-8){1'b0}}, (x[BlockW-1] ? RbConst : 8'h00)};
  endfunction

endpackage

FILE: design/acmac_stream_if.sv
interface acmac_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/acmac_round.sv
// One AES round per cycle while ctrl_i.step is set, on a shared state register.
module acmac_round (
  input  logic                clk_i,
  input  acmac_pkg::rnd_ctrl_t ctrl_i,
  input  acmac_pkg::block_t   data_i,
  input  acmac_pkg::block_t   rk_i,
  output acmac_pkg::block_t   state_o
);
  import acmac_pkg::*;

  block_t state_q, state_d;
  block_t sb, sr, mc;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[BlockW-1-8*i -: 8] = sbox(byte_of(state_q, i));
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[BlockW-1-8*(i+4*c) -: 8] = byte_of(sb, i + 4*((c+i) % 4));
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, x;
      a0 = byte_of(sr, 4*c);
      a1 = byte_of(sr, 4*c+1);
      a2 = byte_of(sr, 4*c+2);
      a3 = byte_of(sr, 4*c+3);
      x  = a0 ^ a1 ^ a2 ^ a3;
      mc[BlockW-1-8*(4*c)   -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
      mc[BlockW-1-8*(4*c+1) -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
      mc[BlockW-1-8*(4*c+2) -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
      mc[BlockW-1-8*(4*c+3) -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
    end
    state_d = state_q;
    if (ctrl_i.load) begin
      state_d = data_i ^ rk_i;
    end else if (ctrl_i.step) begin
      state_d = (ctrl_i.last ? sr : mc) ^ rk_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign state_o = state_q;
endmodule

FILE: design/acmac_key_sched.sv
// Key expansion, one round key per cycle, into an 11-entry register file.
module acmac_key_sched (
  input  logic                            clk_i,
  input  logic                            start_i,
  input  acmac_pkg::block_t               key_i,
  input  logic [acmac_pkg::RoundW-1:0]    rd_idx_i,
  output acmac_pkg::block_t               rk_o
);
  import acmac_pkg::*;

  block_t              rk_q [NumRk];
  block_t              cur_q, cur_d;
  logic [RoundW-1:0]   idx_q;
  logic [7:0]          rcon_q;
  logic                busy_q;
  logic [31:0]         t;

  always_comb begin
    logic [31:0] w0, w1, w2, w3, r;
    r  = cur_q[31:0];
    t  = {sbox(r[23:16]), sbox(r[15:8]), sbox(r[7:0]), sbox(r[31:24])} ^ {rcon_q, 24'h0};
    w0 = cur_q[127:96] ^ t;
    w1 = cur_q[95:64] ^ w0;
    w2 = cur_q[63:32] ^ w1;
    w3 = cur_q[31:0] ^ w2;
    cur_d = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cur_q    <= key_i;
      rk_q[0]  <= key_i;
      idx_q    <= RoundW'(1);
      rcon_q   <= 8'h01;
      busy_q   <= 1'b1;
    end else if (busy_q) begin
      cur_q       <= cur_d;
      rk_q[idx_q] <= cur_d;
      rcon_q      <= xtime(rcon_q);
      idx_q       <= idx_q + RoundW'(1);
      busy_q      <= (idx_q != RoundW'(NumRk - 1));
    end
  end

  assign rk_o = rk_q[rd_idx_i];
endmodule

FILE: design/aes_cmac_engine.sv
// AES-128 CMAC engine. Message blocks arrive on in_if, 16 bytes each; the
// tag of a message is a transfer on out_if after the block with last_block
// set. Each block passes through the cycle of its input transfer, one load,
// ten rounds through the single iterative AES round unit, and the post
// cycle for the result. The CBC chain through that unit sets the rate.
// After a key write the first block also pays for key expansion and an AES
// of zero for the subkeys. A finished tag waits in its own register, so the
// next message can start while the tag is stalled; the engine only holds in
// the post cycle when a second tag is ready and the first has not yet been
// taken. The user must write keys through cfg_we_i/cfg_idx_i/cfg_wdata_i
// only while idle; the engine does not enforce it. A key write forces
// re-derivation.
module aes_cmac_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [acmac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [acmac_pkg::HalfW-1:0]    cfg_wdata_i,
  acmac_stream_if.sink                   in_if,
  acmac_stream_if.source                 out_if
);
  import acmac_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StKexp  = 6'b000010,
    StSubk  = 6'b000100,
    StLoad  = 6'b001000,
    StRound = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  state_e            st_q, st_d;
  logic [HalfW-1:0]  key_up_q, key_lo_q;
  logic              keys_ready_q;
  logic [RoundW-1:0] cnt_q, cnt_d;
  logic              subk_pass_q;  // current AES run is AES(0) for L
  block_t            chain_q, k1_q, k2_q, tag_q;
  logic              last_q, tag_v_q;
  in_item_t          item;
  in_item_t          held_q;       // raw block, held while subkeys are derived
  rnd_ctrl_t         rc;
  block_t            rk, aes_out, msg, padded, mask, pad;
  logic              kstart;
  logic              done_go;      // post cycle may retire its result

  assign item = in_if.payload;

  // last block prep from the held block: pad short blocks, choose subkey
  always_comb begin
    msg = {held_q.data_upper, held_q.data_lower};
    mask = '0;
    pad  = '0;
    for (int i = 0; i < 16; i++) begin
      if (CntW'(i) < held_q.valid_bytes) mask[BlockW-1-8*i -: 8] = 8'hff;
      if (CntW'(i) == held_q.valid_bytes) pad[BlockW-1-8*i -: 8] = PadMark;
    end
    if (!held_q.last_block) padded = msg;
    else if (held_q.valid_bytes >= BlockBytes) padded = msg ^ k1_q;
    else padded = (msg & mask) ^ pad ^ k2_q;
  end

  acmac_key_sched u_ks (
    .clk_i    (clk_i),
    .start_i  (kstart),
    .key_i    ({key_up_q, key_lo_q}),
    .rd_idx_i (cnt_q),
    .rk_o     (rk)
  );

  acmac_round u_rnd (
    .clk_i   (clk_i),
    .ctrl_i  (rc),
    .data_i  (subk_pass_q ? block_t'(0) : (chain_q ^ padded)),
    .rk_i    (rk),
    .state_o (aes_out)
  );

  // a new tag may only land when the tag register is free or leaving
  assign done_go = subk_pass_q || !last_q || !tag_v_q || out_if.ready;

  assign in_if.ready  = (st_q == StIdle);
  assign out_if.valid = tag_v_q;
  assign out_if.payload = out_item_t'(tag_q);

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    kstart = 1'b0;
    rc     = '0;
    case (st_q)
      StIdle: begin
        if (in_if.valid && in_if.ready) begin
          cnt_d = '0;
          if (!keys_ready_q) begin
            kstart = 1'b1;
            st_d   = StKexp;
          end else begin
            st_d = StLoad;
          end
        end
      end
      StKexp: begin
        cnt_d = cnt_q + RoundW'(1);
        if (cnt_q == RoundW'(NumRk - 1)) begin
          cnt_d = '0;
          st_d  = StLoad;
        end
      end
      StLoad, StSubk: begin
        rc.load = 1'b1;
        cnt_d   = RoundW'(1);
        st_d    = StRound;
      end
      StRound: begin
        rc.step = 1'b1;
        rc.last = (cnt_q == RoundW'(NumRk - 1));
        cnt_d   = cnt_q + RoundW'(1);
        if (rc.last) begin
          cnt_d = '0;
          st_d  = StDone;
        end
      end
      StDone: begin
        if (done_go) st_d = subk_pass_q ? StLoad : StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= StIdle;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      key_up_q     <= '0;
      key_lo_q     <= '0;
      chain_q      <= '0;
      tag_v_q      <= 1'b0;
      subk_pass_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegKeyUpper: key_up_q <= cfg_wdata_i;
          RegKeyLower: key_lo_q <= cfg_wdata_i;
          default: ;
        endcase
        keys_ready_q <= 1'b0;
      end
      if (out_if.valid && out_if.ready) tag_v_q <= 1'b0;
      if (st_q == StIdle && in_if.valid && in_if.ready) begin
        subk_pass_q <= !keys_ready_q;
      end
      if (st_q == StDone && done_go) begin
        if (subk_pass_q) begin
          subk_pass_q  <= 1'b0;
          keys_ready_q <= 1'b1;
        end else if (last_q) begin
          chain_q <= '0;
          tag_v_q <= 1'b1;
        end else begin
          chain_q <= aes_out;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_if.valid && in_if.ready) last_q <= item.last_block;
    if (st_q == StDone && subk_pass_q) begin
      k1_q <= gf_double(aes_out);
      k2_q <= gf_double(gf_double(aes_out));
    end
    if (st_q == StDone && done_go && !subk_pass_q && last_q) tag_q <= aes_out;
  end

  // input item must hold during subkey derivation: capture raw, pad at load
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_if.valid && in_if.ready) held_q <= item;
  end
endmodule
